// ----- hdl/hse_pkg.sv -----
// Package for the HMAC-SHA1 engine: sequencer types, SHA-1 constants and
// byte packing helpers. No dependencies.
package hse_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int BLK_WORDS   = BLOCK_BYTES / 4;
  localparam int ROUNDS      = 80;
  localparam int TOT_W       = 61;

  localparam logic [31:0] IPAD_W = 32'h3636_3636;
  localparam logic [31:0] OPAD_W = 32'h5c5c_5c5c;
  localparam logic [31:0] PAD_HI = 32'h8000_0000;
  // outer message is 64 key bytes plus 20 digest bytes, in bits
  localparam logic [31:0] OUTER_BITS = 32'((BLOCK_BYTES + 20) * 8);

  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  localparam logic MODE_KEY = 1'b0;
  localparam logic MODE_MSG = 1'b1;

  typedef enum logic [1:0] {PH_IDLE, PH_KEY, PH_MSG} phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_STORE, S_PAD, S_INIT, S_ROUND, S_ADD, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    ST_START, ST_BLOCK, ST_PAD1, ST_PAD2, ST_OKEY, ST_OUT
  } step_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h6745_2301;
      3'd1:    v = 32'hEFCD_AB89;
      3'd2:    v = 32'h98BA_DCFE;
      3'd3:    v = 32'h1032_5476;
      default: v = 32'hC3D2_E1F0;
    endcase
    return v;
  endfunction

  // big-endian: lane 0 is the top byte
  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = w;
    r[8*(3-lane) +: 8] = b;
    return r;
  endfunction

  // 0x80 at byte position idx, zero past it
  function automatic logic [31:0] pad_word(input logic [31:0] w, input logic [3:0] j,
                                           input logic [5:0] idx);
    logic [31:0] r;
    logic [5:0]  pos;
    r = w;
    for (int l = 0; l < 4; l++) begin
      pos = {j, 2'(l)};
      if (pos == idx) r[8*(3-l) +: 8] = 8'h80;
      else if (pos > idx) r[8*(3-l) +: 8] = 8'h00;
    end
    return r;
  endfunction

endpackage

// ----- hdl/hmac_sha1_engine_unit.sv -----
// HMAC-SHA1 engine top level: key store, message block buffer and one shared
// SHA-1 round unit under a sequencer. Depends on hse_pkg.
// A key byte is taken without leaving idle. A message byte is stored, plus a
// compression when it fills a block; the first byte of a message adds one for
// the key block. Last byte: at most 4 compressions, then five digest words, one
// per accepted output cycle. The round unit does one SHA-1 round per cycle.
// Synchronous active-low reset: empty key, idle, SHA-1 initial chaining values.
module hmac_sha1_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] mode
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        out_tlast
);
  import hse_pkg::*;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  step_t  step_r, step_nxt;
  logic [6:0]       fill_r, fill_nxt, fill_v;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [6:0]       rnd_r, rnd_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [31:0] key_r [BLK_WORDS];
  logic [31:0] key_nxt [BLK_WORDS];
  logic [31:0] h_r [5];
  logic [31:0] h_nxt [5];
  logic [31:0] h_sum [5];
  logic [31:0] w_r [BLK_WORDS];
  logic [31:0] w_nxt [BLK_WORDS];
  logic [31:0] dig_r [5];
  logic [31:0] dig_nxt [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic [31:0] f_v, k_v, t_v, ws_v;
  logic [63:0] bits_v;
  logic        in_acc, out_acc;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_OUT);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = {5'd0, cnt_r, h_r[cnt_r]};
  assign out_tlast  = (cnt_r == 3'd4);
  assign bits_v     = {total_r, 3'b000};

  always_comb begin
    if (rnd_r < 7'd20) begin
      f_v = (b_r & c_r) | (~b_r & d_r); k_v = K0;
    end else if (rnd_r < 7'd40) begin
      f_v = b_r ^ c_r ^ d_r; k_v = K1;
    end else if (rnd_r < 7'd60) begin
      f_v = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k_v = K2;
    end else begin
      f_v = b_r ^ c_r ^ d_r; k_v = K3;
    end
    t_v  = {a_r[26:0], a_r[31:27]} + f_v + e_r + k_v + w_r[0];
    ws_v = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    h_sum[0] = h_r[0] + a_r;
    h_sum[1] = h_r[1] + b_r;
    h_sum[2] = h_r[2] + c_r;
    h_sum[3] = h_r[3] + d_r;
    h_sum[4] = h_r[4] + e_r;
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    step_nxt  = step_r;
    fill_nxt  = fill_r;
    fill_v    = fill_r;
    total_nxt = total_r;
    rnd_nxt   = rnd_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    h_nxt     = h_r;
    w_nxt     = w_r;
    dig_nxt   = dig_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; e_nxt = e_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == MODE_KEY) begin
            if (phase_r != PH_KEY) begin
              for (int i = 0; i < BLK_WORDS; i++) key_nxt[i] = '0;
              fill_v = '0;
            end
            fill_nxt = fill_v;
            if (!fill_v[6]) begin
              key_nxt[fill_v[5:2]] = put_byte(key_nxt[fill_v[5:2]], fill_v[1:0], in_tdata);
              fill_nxt = fill_v + 7'd1;
            end
            phase_nxt = in_tlast ? PH_IDLE : PH_KEY;
          end else begin
            byte_nxt = in_tdata;
            last_nxt = in_tlast;
            if (phase_r != PH_MSG) begin
              for (int i = 0; i < 5; i++) h_nxt[i] = iv_word(3'(i));
              for (int i = 0; i < BLK_WORDS; i++) w_nxt[i] = key_r[i] ^ IPAD_W;
              total_nxt = TOT_W'(BLOCK_BYTES);
              phase_nxt = PH_MSG;
              step_nxt  = ST_START;
              state_nxt = S_INIT;
            end else begin
              state_nxt = S_STORE;
            end
          end
        end
      end
      S_STORE: begin
        w_nxt[total_r[5:2]] = put_byte(w_r[total_r[5:2]], total_r[1:0], byte_r);
        total_nxt = total_r + TOT_W'(1);
        if (total_r[5:0] == 6'd63) begin
          step_nxt  = ST_BLOCK;
          state_nxt = S_INIT;
        end else if (last_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PAD: begin
        for (int j = 0; j < BLK_WORDS; j++) w_nxt[j] = pad_word(w_r[j], 4'(j), total_r[5:0]);
        if (total_r[5:0] <= 6'd55) begin
          w_nxt[14] = bits_v[63:32];
          w_nxt[15] = bits_v[31:0];
          step_nxt  = ST_PAD2;
        end else begin
          step_nxt  = ST_PAD1;
        end
        state_nxt = S_INIT;
      end
      S_INIT: begin
        a_nxt = h_r[0]; b_nxt = h_r[1]; c_nxt = h_r[2]; d_nxt = h_r[3]; e_nxt = h_r[4];
        rnd_nxt   = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        a_nxt = t_v;
        b_nxt = a_r;
        c_nxt = {b_r[1:0], b_r[31:2]};
        d_nxt = c_r;
        e_nxt = d_r;
        for (int i = 0; i < BLK_WORDS - 1; i++) w_nxt[i] = w_r[i+1];
        w_nxt[BLK_WORDS-1] = {ws_v[30:0], ws_v[31]};
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'(ROUNDS - 1)) state_nxt = S_ADD;
      end
      S_ADD: begin
        h_nxt = h_sum;
        unique case (step_r)
          ST_START: state_nxt = S_STORE;
          ST_BLOCK: state_nxt = last_r ? S_PAD : S_IDLE;
          ST_PAD1: begin
            for (int i = 0; i < BLK_WORDS; i++) w_nxt[i] = '0;
            w_nxt[14] = bits_v[63:32];
            w_nxt[15] = bits_v[31:0];
            step_nxt  = ST_PAD2;
            state_nxt = S_INIT;
          end
          ST_PAD2: begin
            dig_nxt = h_sum;
            for (int i = 0; i < 5; i++) h_nxt[i] = iv_word(3'(i));
            for (int i = 0; i < BLK_WORDS; i++) w_nxt[i] = key_r[i] ^ OPAD_W;
            step_nxt  = ST_OKEY;
            state_nxt = S_INIT;
          end
          ST_OKEY: begin
            for (int i = 0; i < BLK_WORDS; i++) w_nxt[i] = '0;
            for (int i = 0; i < 5; i++) w_nxt[i] = dig_r[i];
            w_nxt[5]  = PAD_HI;
            w_nxt[15] = OUTER_BITS;
            step_nxt  = ST_OUT;
            state_nxt = S_INIT;
          end
          ST_OUT: begin
            cnt_nxt   = '0;
            state_nxt = S_OUT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_OUT: begin
        if (out_acc) begin
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == 3'd4) begin
            cnt_nxt   = '0;
            for (int i = 0; i < 5; i++) h_nxt[i] = iv_word(3'(i));
            total_nxt = '0;
            phase_nxt = PH_IDLE;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_IDLE;
      step_r  <= ST_START;
      fill_r  <= '0;
      total_r <= '0;
      rnd_r   <= '0;
      cnt_r   <= '0;
      for (int i = 0; i < BLK_WORDS; i++) key_r[i] <= '0;
      for (int i = 0; i < 5; i++) h_r[i] <= iv_word(3'(i));
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
      rnd_r   <= rnd_nxt;
      cnt_r   <= cnt_nxt;
      key_r   <= key_nxt;
      h_r     <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    dig_r  <= dig_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    d_r    <= d_nxt;
    e_r    <= e_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

endmodule

// ----- hdl/hse_checker.sv -----
// Port-level checks for the HMAC-SHA1 engine, bound to its top level.
// No package dependency.
module hse_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while digest pending");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[34:32] == 3'd4)))
    else $error("tlast not on word four");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[34:32] == $past(out_tdata[34:32]) + 3'd1))
    else $error("digest words out of sequence");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled word changed");

endmodule

bind hmac_sha1_engine_unit hse_port_checks u_hse_port_checks (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);

// ----- bench/hse_checker.sv -----
// Checker for the HMAC-SHA1 engine: watches the byte and digest channels,
// predicts the digest words and compares them. Depends on hse_pkg.
`timescale 1ns / 100ps
module hse_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_words
);
  import hse_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        lst;
  } digest_word_t;

  digest_word_t digest_q[$];
  logic [7:0]   key_mem[BLOCK_BYTES];
  int           key_len;
  phase_t       ph;
  logic [31:0]  inner_h[5];
  logic [7:0]   blk_mem[BLOCK_BYTES];
  logic [63:0]  msg_total;

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic sha1_block(inout logic [31:0] h[5], input logic [7:0] b[BLOCK_BYTES]);
    logic [31:0] w[80];
    logic [31:0] a, bb, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = h[0]; bb = h[1]; c = h[2]; d = h[3]; e = h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (bb & c) | (~bb & d); k = K0;
      end else if (i < 40) begin
        f = bb ^ c ^ d; k = K1;
      end else if (i < 60) begin
        f = (bb & c) | (bb & d) | (c & d); k = K2;
      end else begin
        f = bb ^ c ^ d; k = K3;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(bb, 30); bb = a; a = t;
    end
    h[0] += a; h[1] += bb; h[2] += c; h[3] += d; h[4] += e;
  endtask

  task automatic sha1_finish(inout logic [31:0] h[5], inout logic [7:0] b[BLOCK_BYTES],
                             input logic [63:0] total);
    int          p;
    logic [63:0] bits;
    p = int'(total[5:0]);
    bits = total << 3;
    b[p] = 8'h80;
    p++;
    if (p > 56) begin
      for (int i = p; i < 64; i++) b[i] = 8'h00;
      sha1_block(h, b);
      p = 0;
    end
    for (int i = p; i < 56; i++) b[i] = 8'h00;
    for (int i = 0; i < 8; i++) b[56+i] = bits[8*(7-i) +: 8];
    sha1_block(h, b);
  endtask

  task automatic reset_iv(output logic [31:0] h[5]);
    h[0] = 32'h6745_2301; h[1] = 32'hEFCD_AB89; h[2] = 32'h98BA_DCFE;
    h[3] = 32'h1032_5476; h[4] = 32'hC3D2_E1F0;
  endtask

  task automatic take_byte(input logic mode, input logic [7:0] b, input logic lst);
    logic [31:0] oh[5];
    logic [7:0]  ob[BLOCK_BYTES];
    digest_word_t dw;
    if (mode == MODE_KEY) begin
      if (ph != PH_KEY) begin
        foreach (key_mem[i]) key_mem[i] = 8'h00;
        key_len = 0;
      end
      if (key_len < BLOCK_BYTES) begin
        key_mem[key_len] = b;
        key_len++;
      end
      ph = lst ? PH_IDLE : PH_KEY;
      return;
    end
    if (ph != PH_MSG) begin
      reset_iv(inner_h);
      foreach (blk_mem[i]) blk_mem[i] = key_mem[i] ^ 8'h36;
      sha1_block(inner_h, blk_mem);
      msg_total = 64;
    end
    ph = PH_MSG;
    blk_mem[msg_total[5:0]] = b;
    msg_total++;
    if (msg_total[5:0] == 0) sha1_block(inner_h, blk_mem);
    if (!lst) return;
    sha1_finish(inner_h, blk_mem, msg_total);
    reset_iv(oh);
    foreach (ob[i]) ob[i] = key_mem[i] ^ 8'h5c;
    sha1_block(oh, ob);
    for (int i = 0; i < 20; i++) ob[i] = inner_h[i/4][8*(3-i%4) +: 8];
    sha1_finish(oh, ob, 64'd84);
    for (int i = 0; i < 5; i++) begin
      dw.word = oh[i]; dw.idx = 3'(i); dw.lst = (i == 4);
      digest_q.push_back(dw);
    end
    reset_iv(inner_h);
    msg_total = 0;
    ph = PH_IDLE;
  endtask

  assign pending_words = digest_q.size();

  always @(posedge clk) begin
    digest_word_t want;
    if (!rst_n) begin
      foreach (key_mem[i]) key_mem[i] = 8'h00;
      key_len = 0;
      ph = PH_IDLE;
      msg_total = 0;
      reset_iv(inner_h);
      digest_q.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word: %h last %b", out_tdata, out_tlast);
        end else begin
          want = digest_q.pop_front();
          if (out_tdata[31:0] !== want.word || out_tdata[34:32] !== want.idx ||
              out_tdata[39:35] !== 5'd0 || out_tlast !== want.lst) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp %h idx %0d last %b, got %h idx %0d last %b",
                       want.word, want.idx, want.lst, out_tdata[31:0],
                       out_tdata[34:32], out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) take_byte(in_tuser, in_tdata, in_tlast);
    end
  end
endmodule

// ----- bench/tb_top.sv -----
// Top of the HMAC-SHA1 engine bench: clock, reset, byte stimulus with random
// idling and the verdict. Depends on hse_pkg, hse_checker and the engine RTL.
`timescale 1ns / 100ps
module tb_top;
  import hse_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = MODE_KEY;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          pending_words;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles = 0;
  int          sent = 0;

  always #6 clk = ~clk;

  hmac_sha1_engine_unit uut (.*);

  hse_checker chk (.*);

  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_word(input logic mode, input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= b;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // drop valid and wait until every predicted word has come out
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
  endtask

  task automatic send_key(input int len);
    for (int i = 0; i < len; i++)
      send_word(MODE_KEY, 8'($urandom), i == len - 1);
  endtask

  task automatic send_msg(input int len);
    for (int i = 0; i < len; i++)
      send_word(MODE_MSG, 8'($urandom), i == len - 1);
  endtask

  initial begin
    int phase_items;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    // no key loaded yet, then extremes of byte values
    send_word(MODE_MSG, 8'h00, 1'b1);
    send_word(MODE_KEY, 8'hff, 1'b1);
    send_word(MODE_MSG, 8'hff, 1'b0);
    send_word(MODE_MSG, 8'h00, 1'b1);
    // key byte mid-message drops it; message byte cuts a key short
    send_word(MODE_MSG, 8'h5a, 1'b0);
    send_word(MODE_KEY, 8'ha5, 1'b0);
    send_word(MODE_KEY, 8'h3c, 1'b0);
    send_word(MODE_MSG, 8'h81, 1'b1);
    send_word(MODE_KEY, 8'h7e, 1'b1);
    send_msg(3);
    wait_drain();
    // long key, message across block and padding boundaries
    send_key(70);
    send_msg(56);
    send_msg(64);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 88 : 0;
      recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 15 : 0;
      phase_items = sent + 70;
      while (sent < phase_items) begin
        case ($urandom_range(9))
          0: send_key($urandom_range(1, 66));
          1: send_word(MODE_KEY, 8'($urandom), 1'($urandom));
          2: send_msg($urandom_range(1, 4));
          3: send_msg($urandom_range(54, 66));
          default: begin
            if ($urandom_range(3) == 0) send_key($urandom_range(1, 20));
            send_msg($urandom_range(1, 24));
          end
        endcase
      end
      wait_drain();
    end
    repeat (50) @(negedge clk);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
